/* hw/rtl/banded_priority_ready_queue_assert.svh */
// Assertion macros used by the queue RTL.
`ifndef BANDED_PRIORITY_READY_QUEUE_ASSERT_SVH
`define BANDED_PRIORITY_READY_QUEUE_ASSERT_SVH
`define BPRQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
`define BPRQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

/* hw/rtl/bprq_pkg.sv */
package bprq_pkg;
  localparam int unsigned BandCount = 3;
  localparam logic [7:0] Band1Lo = 8'd100;
  localparam logic [7:0] Band2Lo = 8'd130;
  localparam logic [7:0] PrioLimit = 8'd140;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0] prio;
    logic [1:0] policy;
    logic [15:0] rtime;
  } entry_t;

  // Command broadcast to every cell of the row during one pass.
  typedef struct packed {
    logic ins;
    logic rem;
    entry_t ent;
  } cmd_t;
endpackage

/* hw/rtl/bprq_cell.sv */
module bprq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            clear,
  input  logic            use_r,
  input  bprq_pkg::cmd_t  cmd,
  input  logic            ld_vld,
  input  bprq_pkg::entry_t ld_ent,
  input  logic            prev_vld,
  input  bprq_pkg::entry_t prev_ent,
  input  logic            prev_hold,
  input  logic [4:0]      prev_del,
  input  logic            next_vld,
  input  bprq_pkg::entry_t next_ent,
  input  logic            next_hit_n,
  input  logic            next2_vld,
  input  bprq_pkg::entry_t next2_ent,
  output logic            vld_o,
  output bprq_pkg::entry_t ent_o,
  output logic            hold_o,
  output logic            hit_o
);
  logic vld_r, vld_nxt;
  bprq_pkg::entry_t ent_r, ent_nxt;

  // An entry stays in place when its priority is at least the new one.
  assign hold_o = vld_r && (ent_r.prio >= cmd.ent.prio);
  assign hit_o = vld_r && (ent_r.pid == cmd.ent.pid);
  assign vld_o = vld_r;
  assign ent_o = ent_r;

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    if (load) begin
      vld_nxt = ld_vld;
      ent_nxt = ld_ent;
    end else if (use_r && cmd.ins) begin
      if (!hold_o) begin
        if (prev_hold) begin
          vld_nxt = 1'b1;
          ent_nxt = cmd.ent;
        end else begin
          vld_nxt = prev_vld;
          ent_nxt = prev_ent;
        end
      end
    end else if (use_r && cmd.rem) begin
      if (hit_o || prev_del != 5'd0) begin
        vld_nxt = next_vld && !next_hit_n;
        ent_nxt = next_ent;
        if (next_hit_n) begin
          vld_nxt = next2_vld;
          ent_nxt = next2_ent;
        end
      end
    end
    if (clear) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    ent_r <= ent_nxt;
  end
endmodule

/* hw/rtl/banded_priority_ready_queue.sv */
// Each CPU owns three ready queues chosen by static priority band (0-99, 100-129,
// 130-139), kept sorted highest priority first and oldest first among equals.
// The addressed queue is read from a queue memory, loaded into a row of cells,
// updated there by an insert or by removal passes (one matching entry per
// cycle), and written back. An insert passes through the read, load, update,
// write-back and result steps; a full queue goes from load to the result. A
// remove makes one update pass per removed entry and a final pass that finds no
// match. A priority outside the bands is answered directly from idle, and the
// next request is taken once the result has been accepted.
module banded_priority_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CPU_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[0], cpu_index[2:1], task_pid[18:3], static_prio[26:19],
  // policy_kind[28:27], remaining_time[44:29], zero fill to 48 bits
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], band[4:3], queue_count[9:5], zero fill to 16 bits
  output logic [15:0] out_tdata
);
  `include "banded_priority_ready_queue_assert.svh"

  localparam int unsigned QCount = CPU_COUNT * bprq_pkg::BandCount;
  localparam int unsigned QW = (QCount > 1) ? $clog2(QCount) : 1;
  localparam int unsigned DW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_WORK, S_WRITE, S_OUT} state_t;
  state_t state_r;

  logic [2:0] op_status_r;
  logic [1:0] band_r;
  logic [QW-1:0] q_r;
  logic [DW-1:0] fill_r [QCount];
  logic [DW-1:0] cnt_r;
  bprq_pkg::cmd_t cmd_r;
  logic found_r;
  logic out_vld_r;
  logic [15:0] out_data_r;

  // Queue memory: one row holds the whole queue.
  logic [QUEUE_DEPTH*43-1:0] mem [QCount];
  logic [QUEUE_DEPTH*43-1:0] rd_r, wr_row;

  logic load, clear_unused, use_ins, use_rem;
  logic vld [QUEUE_DEPTH];
  bprq_pkg::entry_t ent [QUEUE_DEPTH];
  logic hold [QUEUE_DEPTH];
  logic hit [QUEUE_DEPTH];
  logic [4:0] dummy_del [QUEUE_DEPTH];
  logic any_hit;

  // Input decode.
  logic in_op;
  logic [1:0] in_cpu;
  bprq_pkg::entry_t in_ent;
  logic [3:0] cpu_w;
  logic [1:0] in_band;
  assign in_op = in_tdata[0];
  assign in_cpu = in_tdata[2:1];
  assign in_ent = '{pid: in_tdata[18:3], prio: in_tdata[26:19],
                    policy: in_tdata[28:27], rtime: in_tdata[44:29]};

  // The CPU index wraps modulo the CPU count; three subtractions cover a 2-bit index.
  always_comb begin
    cpu_w = 4'(in_cpu);
    for (int k = 0; k < 3; k++) begin
      if (32'(cpu_w) >= CPU_COUNT) cpu_w = cpu_w - 4'(CPU_COUNT);
    end
  end

  assign in_band = (in_ent.prio < bprq_pkg::Band1Lo) ? 2'd0 :
                   (in_ent.prio < bprq_pkg::Band2Lo) ? 2'd1 : 2'd2;

  assign in_tready = (state_r == S_IDLE) && !out_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;

  assign load = (state_r == S_LOAD);
  assign clear_unused = 1'b0;
  assign use_ins = (state_r == S_WORK) && cmd_r.ins;
  assign use_rem = (state_r == S_WORK) && cmd_r.rem;

  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) any_hit = any_hit | hit[i];
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic pv, ph, nv, nh, n2v;
      bprq_pkg::entry_t pe, ne, n2e;
      logic [4:0] pd;
      logic use_g;
      if (g == 0) begin : g_first
        assign pv = 1'b0; assign pe = '0; assign ph = 1'b1; assign pd = 5'd0;
      end else begin : g_mid
        assign pv = vld[g-1]; assign pe = ent[g-1]; assign ph = hold[g-1];
        assign pd = dummy_del[g-1];
      end
      if (g + 1 < QUEUE_DEPTH) begin : g_nx
        assign nv = vld[g+1]; assign ne = ent[g+1]; assign nh = 1'b0;
      end else begin : g_nl
        assign nv = 1'b0; assign ne = '0; assign nh = 1'b0;
      end
      assign n2v = 1'b0; assign n2e = '0;
      // Marks that a hit lies at or before this cell; cells from the first hit on
      // shift one place toward the head, removing one match per pass.
      assign dummy_del[g] = (pd != 5'd0 || hit[g]) ? 5'd1 : 5'd0;
      assign use_g = cmd_r.ins ? use_ins : use_rem;
      bprq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .load(load), .clear(clear_unused),
        .use_r(use_g), .cmd(cmd_r),
        .ld_vld(SW'(g) < cnt_r[SW-1:0] || cnt_r == DW'(QUEUE_DEPTH)),
        .ld_ent(rd_r[g*43 +: 42]),
        .prev_vld(pv), .prev_ent(pe), .prev_hold(ph), .prev_del(pd),
        .next_vld(nv), .next_ent(ne), .next_hit_n(nh),
        .next2_vld(n2v), .next2_ent(n2e),
        .vld_o(vld[g]), .ent_o(ent[g]), .hold_o(hold[g]), .hit_o(hit[g])
      );
      assign wr_row[g*43 +: 43] = {vld[g], ent[g]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (state_r == S_READ) rd_r <= mem[q_r];
    if (state_r == S_WRITE) mem[q_r] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_vld_r <= 1'b0;
      for (int i = 0; i < QCount; i++) fill_r[i] <= '0;
    end else begin
      if (out_vld_r && out_tready) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r.ent <= in_ent;
            cmd_r.ins <= (in_op == bprq_pkg::OP_INSERT);
            cmd_r.rem <= (in_op == bprq_pkg::OP_REMOVE);
            band_r <= in_band;
            q_r <= QW'(32'(cpu_w) * bprq_pkg::BandCount + 32'(in_band));
            found_r <= 1'b0;
            if (in_ent.prio >= bprq_pkg::PrioLimit) begin
              out_data_r <= {6'd0, 5'd0, 2'd0, bprq_pkg::ST_RANGE};
              out_vld_r <= 1'b1;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          cnt_r <= fill_r[q_r];
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (cmd_r.ins && cnt_r == DW'(QUEUE_DEPTH)) begin
            op_status_r <= bprq_pkg::ST_FULL;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WORK;
          end
        end
        S_WORK: begin
          if (cmd_r.ins) begin
            cnt_r <= cnt_r + DW'(1);
            op_status_r <= bprq_pkg::ST_INSERTED;
            state_r <= S_WRITE;
          end else if (any_hit) begin
            cnt_r <= cnt_r - DW'(1);
            found_r <= 1'b1;
          end else begin
            op_status_r <= found_r ? bprq_pkg::ST_REMOVED : bprq_pkg::ST_NOTFOUND;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          fill_r[q_r] <= cnt_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_data_r <= {6'd0, 5'(cnt_r), band_r, op_status_r};
          out_vld_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BPRQ_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_tready, "accept while busy")
  `BPRQ_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, state_r == S_WORK, cnt_r <= DW'(QUEUE_DEPTH), "count above depth")
  `BPRQ_ASSERT_NEXT(a_out_after, clk, rst_n, state_r == S_OUT, out_vld_r, "result not shown")
endmodule
